// ===== sv/lom_pkg.sv =====
package lom_pkg;

	typedef struct packed {
		logic        func;
		logic [15:0] order_id;
		logic [15:0] price;
		logic [15:0] amount;
		logic [7:0]  client_id;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  dest_client;
		logic [15:0] result_order_id;
		logic [15:0] result_price;
		logic [15:0] result_amount;
		logic [1:0]  reason;
		logic        last;
	} out_item_t;

	// one resting order as read from the book
	typedef struct packed {
		logic        valid;
		logic [15:0] order_id;
		logic [7:0]  client;
		logic [15:0] price;
		logic [15:0] amount;
		logic [31:0] arrival;
	} entry_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_PLACE,
		WR_CLEAR,
		WR_AMOUNT
	} wr_op_t;

	// write command from the sequencer to the book
	typedef struct packed {
		wr_op_t      op;
		logic        side;
		logic [15:0] order_id;
		logic [7:0]  client;
		logic [15:0] price;
		logic [15:0] amount;
		logic [31:0] arrival;
	} book_wr_t;

	localparam logic [1:0] KIND_PLACED   = 2'd0;
	localparam logic [1:0] KIND_TRADED   = 2'd1;
	localparam logic [1:0] KIND_CANCELED = 2'd2;
	localparam logic [1:0] KIND_REJECTED = 2'd3;

	localparam logic [1:0] RSN_NONE    = 2'd0;
	localparam logic [1:0] RSN_USER    = 2'd0;
	localparam logic [1:0] RSN_FILLED  = 2'd1;
	localparam logic [1:0] RSN_INVALID = 2'd0;
	localparam logic [1:0] RSN_DUP     = 2'd1;
	localparam logic [1:0] RSN_FULL    = 2'd2;

	localparam logic FUNC_PLACE  = 1'b0;
	localparam logic FUNC_CANCEL = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CSCAN,
		S_UCAN,
		S_DUP,
		S_REJ,
		S_BEST,
		S_FILL,
		S_E_TIN,
		S_E_TREST,
		S_E_CREST,
		S_E_CIN,
		S_REST,
		S_FLUSH
	} state_t;

endpackage

// ===== sv/limit_order_matching.sv =====
// A cancel scans both sides of the book for its order id; a valid place first scans both sides
// for a duplicate id, then scans the opposite side for the best order before each fill and emits
// its results one at a time, all through the single book read port stepped one slot a cycle.
// One item at a time: in_stall stays high until its last result sits in the output register,
// and the next item is taken from the idle state.
// Reset clears all occupancy bits, the arrival counter and both output stages at once.
module limit_order_matching #(
	parameter int BOOK_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lom_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output lom_pkg::out_item_t  out_data
);
	import lom_pkg::*;

	localparam int IW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
	localparam logic [IW-1:0] IDX_LAST = IW'(BOOK_DEPTH - 1);

	state_t      state_q, state_d;
	logic [15:0] id_q, price_q, rem_q;
	logic [7:0]  cl_q;
	logic [1:0]  rej_q;
	logic        sc_side_q;
	logic [IW-1:0] idx_q;
	logic        free_found_q;
	logic [IW-1:0] free_idx_q;
	logic        best_found_q;
	logic [IW-1:0] best_idx_q;
	logic [15:0] best_price_q, best_amt_q, best_id_q;
	logic [31:0] best_arr_q;
	logic [7:0]  best_cl_q;
	logic [15:0] t_q, ra_q;
	logic [31:0] arrival_q;
	out_item_t   pend_q, out_q;
	logic        pend_valid_q, out_valid_q;

	entry_t      rd;
	book_wr_t    wr;
	logic [IW-1:0] wr_idx;

	logic        item_side;
	logic        out_free, can_push, emit_req, fire, flush_fire, better, crosses, idx_end;
	out_item_t   emit_item;
	logic [15:0] t_d;

	assign item_side  = id_q[0];
	assign out_free  = !out_valid_q || !out_stall;
	assign can_push  = !pend_valid_q || out_free;
	assign fire      = emit_req && can_push;
	assign flush_fire = (state_q == S_FLUSH) && can_push;
	assign idx_end   = (idx_q == IDX_LAST);
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	lom_book #(.DEPTH(BOOK_DEPTH), .IW(IW)) u_book (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_side (sc_side_q),
		.rd_idx  (idx_q),
		.rd_entry(rd),
		.wr      (wr),
		.wr_idx  (wr_idx)
	);

	// compare unit: rank the scanned slot against the best so far
	always_comb begin
		better = !best_found_q;
		if (best_found_q) begin
			if (rd.price != best_price_q)
				better = sc_side_q ? (rd.price < best_price_q) : (rd.price > best_price_q);
			else
				better = (rd.arrival < best_arr_q);
		end
		crosses = item_side ? (price_q <= best_price_q) : (price_q >= best_price_q);
		t_d   = (rem_q < best_amt_q) ? rem_q : best_amt_q;
	end

	// next state, result and book write
	always_comb begin
		state_d   = state_q;
		emit_req  = 1'b0;
		emit_item = '0;
		wr        = '0;
		wr.op     = WR_NONE;
		wr_idx    = best_idx_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_data.func == FUNC_CANCEL)
						state_d = S_CSCAN;
					else if (in_data.price == 16'd0 || in_data.amount == 16'd0)
						state_d = S_REJ;
					else
						state_d = S_DUP;
				end
			end
			S_CSCAN: begin
				if (rd.valid && rd.order_id == id_q)
					state_d = S_UCAN;
				else if (idx_end && sc_side_q)
					state_d = S_FLUSH;
			end
			S_UCAN: begin
				emit_req  = 1'b1;
				emit_item = '{KIND_CANCELED, best_cl_q, id_q, 16'd0, 16'd0, RSN_USER, 1'b0};
				if (fire) begin
					wr.op   = WR_CLEAR;
					wr.side = sc_side_q;
					state_d = S_FLUSH;
				end
			end
			S_DUP: begin
				if (rd.valid && rd.order_id == id_q)
					state_d = S_REJ;
				else if (idx_end && sc_side_q)
					state_d = S_BEST;
			end
			S_REJ: begin
				emit_req  = 1'b1;
				emit_item = '{KIND_REJECTED, cl_q, id_q, 16'd0, 16'd0, rej_q, 1'b0};
				if (fire)
					state_d = S_FLUSH;
			end
			S_BEST: begin
				if (idx_end)
					state_d = S_FILL;
			end
			S_FILL: begin
				state_d = (best_found_q && crosses) ? S_E_TIN : S_REST;
			end
			S_E_TIN: begin
				emit_req  = 1'b1;
				emit_item = '{KIND_TRADED, cl_q, id_q, best_price_q, t_q, RSN_NONE, 1'b0};
				if (fire)
					state_d = S_E_TREST;
			end
			S_E_TREST: begin
				emit_req  = 1'b1;
				emit_item = '{KIND_TRADED, best_cl_q, best_id_q, best_price_q, t_q, RSN_NONE,
					1'b0};
				if (fire) begin
					wr.side   = sc_side_q;
					wr.amount = ra_q;
					wr.op     = (ra_q == 16'd0) ? WR_CLEAR : WR_AMOUNT;
					if (ra_q == 16'd0)
						state_d = S_E_CREST;
					else if (rem_q == 16'd0)
						state_d = S_E_CIN;
					else
						state_d = S_BEST;
				end
			end
			S_E_CREST: begin
				emit_req  = 1'b1;
				emit_item = '{KIND_CANCELED, best_cl_q, best_id_q, 16'd0, 16'd0, RSN_FILLED,
					1'b0};
				if (fire)
					state_d = (rem_q == 16'd0) ? S_E_CIN : S_BEST;
			end
			S_E_CIN: begin
				emit_req  = 1'b1;
				emit_item = '{KIND_CANCELED, cl_q, id_q, 16'd0, 16'd0, RSN_FILLED, 1'b0};
				if (fire)
					state_d = S_FLUSH;
			end
			S_REST: begin
				emit_req = 1'b1;
				if (free_found_q)
					emit_item = '{KIND_PLACED, cl_q, id_q, price_q, rem_q, RSN_NONE, 1'b0};
				else
					emit_item = '{KIND_REJECTED, cl_q, id_q, 16'd0, 16'd0, RSN_FULL, 1'b0};
				if (fire) begin
					if (free_found_q) begin
						wr.op       = WR_PLACE;
						wr.side     = item_side;
						wr.order_id = id_q;
						wr.client   = cl_q;
						wr.price    = price_q;
						wr.amount   = rem_q;
						wr.arrival  = arrival_q;
						wr_idx      = free_idx_q;
					end
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (flush_fire)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// arrival counter, then item registers, scan index and best-order tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arrival_q <= '0;
		end else if (state_q == S_REST && fire && free_found_q) begin
			arrival_q <= arrival_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				id_q         <= in_data.order_id;
				price_q      <= in_data.price;
				rem_q        <= in_data.amount;
				cl_q         <= in_data.client_id;
				rej_q        <= RSN_INVALID;
				sc_side_q    <= 1'b0;
				idx_q        <= '0;
				free_found_q <= 1'b0;
			end
			S_CSCAN, S_DUP: begin
				if (rd.valid && rd.order_id == id_q) begin
					best_idx_q <= idx_q;
					best_cl_q  <= rd.client;
					rej_q      <= RSN_DUP;
				end else begin
					if (state_q == S_DUP && sc_side_q == item_side && !rd.valid &&
						!free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= idx_q;
					end
					if (idx_end) begin
						idx_q <= '0;
						sc_side_q <= (state_q == S_DUP && sc_side_q) ? !item_side : 1'b1;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
					if (state_q == S_DUP && idx_end && sc_side_q)
						best_found_q <= 1'b0;
				end
			end
			S_BEST: begin
				if (rd.valid && better) begin
					best_found_q <= 1'b1;
					best_idx_q   <= idx_q;
					best_price_q <= rd.price;
					best_amt_q   <= rd.amount;
					best_arr_q   <= rd.arrival;
					best_id_q    <= rd.order_id;
					best_cl_q    <= rd.client;
				end
				idx_q <= idx_end ? '0 : idx_q + IW'(1);
			end
			S_FILL: begin
				// trade only against a crossing best order
				if (best_found_q && crosses) begin
					t_q   <= t_d;
					rem_q <= rem_q - t_d;
					ra_q  <= best_amt_q - t_d;
				end
			end
			S_E_CREST, S_E_TREST: begin
				if (fire)
					best_found_q <= 1'b0;
			end
			default: ;
		endcase
	end

	// hold one result back so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (fire) begin
				pend_valid_q <= 1'b1;
				if (pend_valid_q)
					out_valid_q <= 1'b1;
				else if (!out_stall)
					out_valid_q <= 1'b0;
			end else if (flush_fire && pend_valid_q) begin
				pend_valid_q <= 1'b0;
				out_valid_q  <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pend_q <= emit_item;
			if (pend_valid_q)
				out_q <= pend_q;
		end else if (flush_fire && pend_valid_q) begin
			out_q <= out_item_t'({pend_q[$bits(out_item_t)-1:1], 1'b1});
		end
	end

	// checks
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_valid_q)
		else $error("result held back while idle");
	a_trade_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_E_TIN |-> t_q != 16'd0)
		else $error("zero amount trade");
	a_arrival_step: assert property (@(posedge clk) disable iff (!arst_n)
		arrival_q != $past(arrival_q) |-> $past(state_q) == S_REST)
		else $error("arrival counter moved outside resting");

endmodule

// ===== sv/lom_book.sv =====
module lom_book #(
	parameter int DEPTH = 16,
	parameter int IW    = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_side,
	input  logic [IW-1:0]     rd_idx,
	output lom_pkg::entry_t   rd_entry,
	input  lom_pkg::book_wr_t wr,
	input  logic [IW-1:0]     wr_idx
);
	import lom_pkg::*;

	logic        valid_q  [2][DEPTH];
	logic [15:0] id_q     [2][DEPTH];
	logic [7:0]  client_q [2][DEPTH];
	logic [15:0] price_q  [2][DEPTH];
	logic [15:0] amount_q [2][DEPTH];
	logic [31:0] arr_q    [2][DEPTH];

	// present the addressed slot to the sequencer
	always_comb begin
		rd_entry.valid    = valid_q[rd_side][rd_idx];
		rd_entry.order_id = id_q[rd_side][rd_idx];
		rd_entry.client   = client_q[rd_side][rd_idx];
		rd_entry.price    = price_q[rd_side][rd_idx];
		rd_entry.amount   = amount_q[rd_side][rd_idx];
		rd_entry.arrival  = arr_q[rd_side][rd_idx];
	end

	// occupancy bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < 2; s++)
				for (int i = 0; i < DEPTH; i++)
					valid_q[s][i] <= 1'b0;
		end else begin
			unique case (wr.op)
				WR_PLACE: valid_q[wr.side][wr_idx] <= 1'b1;
				WR_CLEAR: valid_q[wr.side][wr_idx] <= 1'b0;
				default: ;
			endcase
		end
	end

	// order payload
	always_ff @(posedge clk) begin
		unique case (wr.op)
			WR_PLACE: begin
				id_q[wr.side][wr_idx]     <= wr.order_id;
				client_q[wr.side][wr_idx] <= wr.client;
				price_q[wr.side][wr_idx]  <= wr.price;
				amount_q[wr.side][wr_idx] <= wr.amount;
				arr_q[wr.side][wr_idx]    <= wr.arrival;
			end
			WR_AMOUNT: amount_q[wr.side][wr_idx] <= wr.amount;
			default: ;
		endcase
	end

endmodule
